FILE: design/phc_pkg.sv
// shared types, constants and decode helpers for the program header checker
`default_nettype none

package phc_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] SEG_LOAD   = 32'd1;
  localparam logic [31:0] SEG_INTERP = 32'd3;
  localparam logic [31:0] SEG_PHDR   = 32'd6;

  localparam logic [1:0] CFG_CLASS_IS_64 = 2'd0;
  localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd1;
  localparam logic [1:0] CFG_PAGE_SHIFT  = 2'd2;

  typedef struct packed {
    logic [31:0]       seg_type;
    logic [ADDR_W-1:0] seg_align;
    logic [ADDR_W-1:0] seg_vaddr;
    logic [ADDR_W-1:0] seg_offset;
    logic              last_entry;
  } phc_in_t;

  typedef struct packed {
    logic [1:0] warning_count;
    logic       table_error;
    logic       table_done;
  } phc_out_t;

  // work handed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] align;
    logic [1:0]        warns;
    logic              need_mod;
    logic              err;
    logic              last;
  } phc_job_t;

  typedef struct packed {
    logic       class_is_64;
    logic       big_endian;
    logic [4:0] page_shift;
  } phc_cfg_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    return {swap32(v[31:0]), swap32(v[63:32])};
  endfunction

  function automatic logic [63:0] decode(input logic [63:0] raw, input logic c64,
                                         input logic be);
    logic [63:0] res;
    if (c64) begin
      res = be ? swap64(raw) : raw;
    end else begin
      res = {32'd0, (be ? swap32(raw[31:0]) : raw[31:0])};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/phc_front.sv
// front end: decodes entries, tracks table flags, raises cheap warnings
`default_nettype none

module phc_front
  import phc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire phc_cfg_t cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire phc_in_t  in_data,
  output logic          job_valid,
  input  wire logic     job_ready,
  output phc_job_t      job
);

  logic load_seen_r, header_seen_r, interp_seen_r, failed_r;
  logic load_seen_nxt, header_seen_nxt, interp_seen_nxt, failed_nxt;

  logic [31:0] seg_type;
  logic [63:0] align, vaddr, offset, pmask, v_minus_o, o_minus_v;
  logic        is_load, is_phdr, is_interp, bad, align_gt1, accept;
  logic [1:0]  warns;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  always_comb begin
    seg_type  = cfg.big_endian ? swap32(in_data.seg_type) : in_data.seg_type;
    align     = decode(in_data.seg_align, cfg.class_is_64, cfg.big_endian);
    vaddr     = decode(in_data.seg_vaddr, cfg.class_is_64, cfg.big_endian);
    offset    = decode(in_data.seg_offset, cfg.class_is_64, cfg.big_endian);
    pmask     = (64'd1 << cfg.page_shift) - 64'd1;
    is_load   = (seg_type == SEG_LOAD);
    is_phdr   = (seg_type == SEG_PHDR);
    is_interp = (seg_type == SEG_INTERP);
    align_gt1 = (align > 64'd1);
    bad       = (is_phdr && (header_seen_r || load_seen_r)) ||
                (is_interp && (interp_seen_r || load_seen_r));
    v_minus_o = vaddr - offset;
    o_minus_v = offset - vaddr;

    warns = 2'd0;
    if (is_load && align_gt1 && ((vaddr & pmask) != (offset & pmask))) begin
      warns = 2'd1;
    end
    if (align_gt1 && ((align & (align - 64'd1)) != 64'd0)) begin
      warns = warns + 2'd1;
    end

    job.diff     = (vaddr >= offset) ? v_minus_o : o_minus_v;
    job.align    = align;
    job.last     = in_data.last_entry;
    job.err      = failed_r || bad;
    job.need_mod = !failed_r && !bad && align_gt1;
    job.warns    = (failed_r || bad) ? 2'd0 : warns;

    load_seen_nxt   = load_seen_r;
    header_seen_nxt = header_seen_r;
    interp_seen_nxt = interp_seen_r;
    failed_nxt      = failed_r;
    if (!failed_r) begin
      load_seen_nxt   = load_seen_r || is_load;
      header_seen_nxt = header_seen_r || is_phdr;
      interp_seen_nxt = interp_seen_r || is_interp;
      failed_nxt      = bad;
    end
    if (in_data.last_entry) begin
      load_seen_nxt   = 1'b0;
      header_seen_nxt = 1'b0;
      interp_seen_nxt = 1'b0;
      failed_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_seen_r   <= 1'b0;
      header_seen_r <= 1'b0;
      interp_seen_r <= 1'b0;
      failed_r      <= 1'b0;
    end else if (accept) begin
      load_seen_r   <= load_seen_nxt;
      header_seen_r <= header_seen_nxt;
      interp_seen_r <= interp_seen_nxt;
      failed_r      <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/phc_queue.sv
// small fifo between front and back
`default_nettype none

module phc_queue
  import phc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire phc_job_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output phc_job_t      pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  phc_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/phc_back.sv
// back end: bit-serial remainder of the address distance by the alignment
`default_nettype none

module phc_back
  import phc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     job_valid,
  output logic          job_ready,
  input  wire phc_job_t job,
  output logic          out_valid,
  input  wire logic     out_ready,
  output phc_out_t      out_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  localparam int unsigned STEP_W = $clog2(ADDR_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

  state_t            state_r;
  logic [ADDR_W-1:0] div_r, align_r, rem_r;
  logic [ADDR_W-1:0] rem_nxt;
  logic [ADDR_W:0]   rem_sh;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  phc_out_t          out_data_r;

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, div_r[ADDR_W-1]};
    if (rem_sh >= {1'b0, align_r}) begin
      rem_nxt = ADDR_W'(rem_sh - {1'b0, align_r});
    end else begin
      rem_nxt = rem_sh[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            out_data_r.warning_count <= job.warns;
            out_data_r.table_error   <= job.err;
            out_data_r.table_done    <= job.last;
            div_r   <= job.diff;
            align_r <= job.align;
            rem_r   <= '0;
            step_r  <= '0;
            if (job.need_mod) begin
              state_r <= S_RUN;
            end else begin
              state_r     <= S_DONE;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_RUN: begin
          rem_r  <= rem_nxt;
          div_r  <= {div_r[ADDR_W-2:0], 1'b0};
          step_r <= step_r + STEP_W'(1);
          if (step_r == LAST_STEP) begin
            if (rem_nxt != '0) begin
              out_data_r.warning_count <= out_data_r.warning_count + 2'd1;
            end
            state_r     <= S_DONE;
            out_valid_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/elf_program_header_checker.sv
// top level of the elf program header table checker
// Checks one ELF program header entry per input beat and returns one result beat per
// entry: the number of alignment warnings it raised, the sticky table error and a done
// mark on the last entry, after which the table flags clear. The combinational front
// accepts an entry when the queue has room, decodes it (byte swap, 32/64-bit class
// from the configuration registers), updates the table flags and runs the page and
// power-of-two checks; a QDEPTH-entry queue feeds the back, which finds the remainder
// of |vaddr - offset| by the alignment one bit per cycle. An entry whose alignment is
// above 1 and which has not failed is loaded, runs 64 divider steps and is presented;
// any other entry is presented after its load. The 64-step loop sets the sustained
// rate. Configuration is to be written through cfg_we / cfg_index / cfg_wdata only
// while the block is idle, which the block does not enforce; index 3 is ignored.
`default_nettype none

module elf_program_header_checker
  import phc_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire phc_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output phc_out_t        out_data
);

  // configuration registers
  phc_cfg_t cfg_r;

  // front to queue, queue to back
  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  phc_job_t fq_job, qb_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_is_64 <= 1'b1;
      cfg_r.big_endian  <= 1'b0;
      cfg_r.page_shift  <= 5'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLASS_IS_64: cfg_r.class_is_64 <= cfg_wdata[0];
        CFG_BIG_ENDIAN:  cfg_r.big_endian  <= cfg_wdata[0];
        CFG_PAGE_SHIFT:  cfg_r.page_shift  <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // decode, flag tracking and the cheap checks
  phc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // decouples the combinational front from the long back end
  phc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  // modulo-alignment check and result register
  phc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/phc_verdict_monitor.sv
`timescale 1ns / 1ps
// verdict monitor for the program header checker: predicts each verdict beat and compares
module phc_verdict_monitor
  import phc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  phc_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  phc_out_t   out_data,
  output int         mismatches,
  output int         verdicts_owed
);

  // shadow of the configuration registers
  logic       m_c64 = 1'b1;
  logic       m_be = 1'b0;
  logic [4:0] m_shift = 5'd12;

  // table flags
  logic load_seen = 1'b0;
  logic hdr_seen = 1'b0;
  logic interp_seen = 1'b0;
  logic tbl_failed = 1'b0;

  phc_out_t verdict_q[$];
  phc_out_t want;
  int       err_cnt = 0;

  function automatic logic [63:0] swap_bytes(input logic [63:0] w, input int nbytes);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < nbytes; i++) r[8*i +: 8] = w[8*(nbytes-1-i) +: 8];
    return r;
  endfunction

  function automatic logic [63:0] field_value(input logic [63:0] raw);
    logic [63:0] r;
    if (m_c64) begin
      r = m_be ? swap_bytes(raw, 8) : raw;
    end else begin
      r = m_be ? swap_bytes({32'd0, raw[31:0]}, 4) : {32'd0, raw[31:0]};
    end
    return r;
  endfunction

  // verdict for one entry; updates the table flags
  function automatic phc_out_t predict_verdict(input phc_in_t e);
    logic [63:0] t64;
    logic [31:0] typ;
    logic [63:0] al, va, off, pmask;
    logic [1:0]  warns;
    logic        bad;
    phc_out_t    v;
    t64 = swap_bytes({32'd0, e.seg_type}, 4);
    typ = m_be ? t64[31:0] : e.seg_type;
    al = field_value(e.seg_align);
    va = field_value(e.seg_vaddr);
    off = field_value(e.seg_offset);
    warns = 2'd0;
    bad = 1'b0;
    if (!tbl_failed) begin
      if (typ == SEG_LOAD) begin
        pmask = (64'd1 << m_shift) - 64'd1;
        load_seen = 1'b1;
        if (al > 64'd1 && (va & pmask) != (off & pmask)) warns = warns + 2'd1;
      end
      if (typ == SEG_PHDR) begin
        if (hdr_seen || load_seen) bad = 1'b1;
        hdr_seen = 1'b1;
      end
      if (typ == SEG_INTERP) begin
        if (interp_seen || load_seen) bad = 1'b1;
        interp_seen = 1'b1;
      end
      if (bad) begin
        tbl_failed = 1'b1;
        warns = 2'd0;
      end else if (al > 64'd1) begin
        if ((al & (al - 64'd1)) != 64'd0) warns = warns + 2'd1;
        if ((va % al) != (off % al)) warns = warns + 2'd1;
      end
    end
    v.warning_count = warns;
    v.table_error = tbl_failed;
    v.table_done = e.last_entry;
    if (e.last_entry) begin
      load_seen = 1'b0;
      hdr_seen = 1'b0;
      interp_seen = 1'b0;
      tbl_failed = 1'b0;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      m_c64 = 1'b1;
      m_be = 1'b0;
      m_shift = 5'd12;
      load_seen = 1'b0;
      hdr_seen = 1'b0;
      interp_seen = 1'b0;
      tbl_failed = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLASS_IS_64: m_c64 = cfg_wdata[0];
          CFG_BIG_ENDIAN:  m_be = cfg_wdata[0];
          CFG_PAGE_SHIFT:  m_shift = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat with none expected: %s %0d %s %0d %s %0d",
                 "warning_count", out_data.warning_count,
                 "table_error", out_data.table_error,
                 "table_done", out_data.table_done);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.warning_count !== want.warning_count) begin
            $error("warning_count: expected %0d, got %0d", want.warning_count,
                   out_data.warning_count);
            err_cnt++;
          end
          if (out_data.table_error !== want.table_error) begin
            $error("table_error: expected %0d, got %0d", want.table_error,
                   out_data.table_error);
            err_cnt++;
          end
          if (out_data.table_done !== want.table_done) begin
            $error("table_done: expected %0d, got %0d", want.table_done,
                   out_data.table_done);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) verdict_q.push_back(predict_verdict(in_data));
    end
    mismatches <= err_cnt;
    verdicts_owed <= verdict_q.size();
  end

endmodule

FILE: tb/elf_program_header_checker_tb.sv
`timescale 1ns / 1ps
// testbench top for the program header checker: stimulus, configuration and final verdict
module elf_program_header_checker_tb;
  import phc_pkg::*;

  localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 80;   // idle margin before the registers change
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASES = 8;
  localparam int RANDOM_ENTRIES = 1080;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // segment types other than the checked ones
  localparam logic [31:0] SEG_NULL = 32'd0;
  localparam logic [31:0] SEG_DYNAMIC = 32'd2;
  localparam logic [31:0] SEG_NOTE = 32'd4;
  localparam logic [31:0] SEG_GNU_STACK = 32'h6474_e551;
  localparam logic [31:0] SEG_LOAD_SWAPPED = 32'h0100_0000;
  localparam logic [63:0] ALL_ONES = '1;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CLASS_IS_64;
  logic [4:0] cfg_wdata = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  phc_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  phc_out_t   out_data;

  int mismatches;
  int verdicts_owed;

  // what was last written, so entries can be encoded the way the block reads them
  logic cur_c64 = 1'b1;
  logic cur_be = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int entries_sent = 0;
  int quiet_cycles = 0;

  // per-phase settings; extremes of the page shift included
  logic       phase_c64[PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic       phase_be[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  logic [4:0] phase_shift[PHASES] = '{5'd12, 5'd0, 5'd31, 5'd30, 5'd31, 5'd1, 5'd5, 5'd0};

  elf_program_header_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  phc_verdict_monitor verdict_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // verdict side: random stall per cycle at the current phase's rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any accepted beat on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] swap_bytes(input logic [63:0] w, input int nbytes);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < nbytes; i++) r[8*i +: 8] = w[8*(nbytes-1-i) +: 8];
    return r;
  endfunction

  // logical field value to the raw word; upper half is junk in 32-bit class
  function automatic logic [63:0] raw_field(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    if (cur_c64) begin
      r = cur_be ? swap_bytes(v, 8) : v;
    end else begin
      t = swap_bytes({32'd0, v[31:0]}, 4);
      r = {$urandom(), 32'd0};
      r[31:0] = cur_be ? t[31:0] : v[31:0];
    end
    return r;
  endfunction

  function automatic phc_in_t pack_entry(input logic [31:0] typ, input logic [63:0] al,
                                         input logic [63:0] va, input logic [63:0] off,
                                         input logic last);
    phc_in_t     e;
    logic [63:0] t;
    t = swap_bytes({32'd0, typ}, 4);
    e.seg_type = cur_be ? t[31:0] : typ;
    e.seg_align = raw_field(al);
    e.seg_vaddr = raw_field(va);
    e.seg_offset = raw_field(off);
    e.last_entry = last;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] other_type();
    logic [31:0] t;
    case ($urandom_range(5))
      0: t = SEG_NULL;
      1: t = SEG_DYNAMIC;
      2: t = SEG_NOTE;
      3: t = SEG_GNU_STACK;
      4: t = SEG_LOAD_SWAPPED;   // a load type seen in the wrong byte order
      default: t = $urandom();
    endcase
    return t;
  endfunction

  // one entry beat; valid stays up back to back unless a gap is drawn
  task automatic send_entry(input phc_in_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (!in_ready);
    entries_sent++;
  endtask

  task automatic send_fields(input logic [31:0] typ, input logic [63:0] al,
                             input logic [63:0] va, input logic [63:0] off, input logic last);
    send_entry(pack_entry(typ, al, va, off, last));
  endtask

  // random alignment and addresses, mostly congruent like a real linker output
  task automatic send_segment(input logic [31:0] typ, input logic last);
    logic [63:0] al, va, off;
    int          pick, k;
    pick = $urandom_range(99);
    k = cur_c64 ? $urandom_range(63, 1) : $urandom_range(31, 1);
    if (pick < 8) begin
      al = 64'd0;
    end else if (pick < 16) begin
      al = 64'd1;
    end else if (pick < 82) begin
      al = 64'd1 << (($urandom_range(99) < 70) ? $urandom_range(16, 1) : k);
    end else begin
      al = rand64();
    end
    va = rand64();
    off = rand64();
    if (!cur_c64) begin
      al[63:32] = 32'd0;
      va[63:32] = 32'd0;
      off[63:32] = 32'd0;
    end
    if (al > 64'd1 && $urandom_range(99) < 75) va = va - (va % al) + (off % al);
    send_fields(typ, al, va, off, last);
  endtask

  // one table: headers first, then loads and others; some tables get a misplaced header
  task automatic send_table();
    logic [31:0] kinds[$];
    int          n, spot;
    n = $urandom_range(6, 1);
    if ($urandom_range(99) < 50) kinds.push_back(SEG_PHDR);
    if ($urandom_range(99) < 50) kinds.push_back(SEG_INTERP);
    for (int i = 0; i < n; i++) begin
      kinds.push_back(($urandom_range(99) < 60) ? SEG_LOAD : other_type());
    end
    if ($urandom_range(99) < 20) begin
      spot = $urandom_range(kinds.size());
      kinds.insert(spot, $urandom_range(1) ? SEG_PHDR : SEG_INTERP);
    end
    foreach (kinds[i]) send_segment(kinds[i], i == kinds.size() - 1);
  endtask

  // stop sending and wait until every verdict is back
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic configure(input logic c64, input logic be, input logic [4:0] shift);
    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_CLASS_IS_64, {4'd0, c64});
    write_reg(CFG_BIG_ENDIAN, {4'd0, be});
    write_reg(CFG_PAGE_SHIFT, shift);
    // unused index must change nothing
    write_reg(CFG_UNUSED, 5'($urandom()));
    cfg_we <= 1'b0;
    cur_c64 = c64;
    cur_be = be;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed tables with reset settings: 64-bit, little endian, 4k pages
    // well-formed table: page and modulo warnings, non-power-of-two alignment
    send_fields(SEG_PHDR, 64'd8, 64'h40, 64'h40, 1'b0);
    send_fields(SEG_INTERP, 64'd1, 64'h238, 64'h238, 1'b0);
    send_fields(SEG_LOAD, 64'h1000, 64'h40_0000, 64'd0, 1'b0);
    send_fields(SEG_LOAD, 64'h1000, 64'h40_1010, 64'h1000, 1'b0);
    send_fields(SEG_LOAD, 64'd3, 64'd1, 64'd2, 1'b0);
    send_fields(SEG_NULL, ALL_ONES, ALL_ONES, 64'd0, 1'b1);
    // header after a load fails, later entries ignored until the last
    send_fields(SEG_LOAD, 64'h20_0000, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_PHDR, 64'd8, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_LOAD, 64'd3, 64'd1, 64'd2, 1'b0);
    send_fields(SEG_INTERP, 64'd1, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_NULL, 64'd0, 64'd0, 64'd0, 1'b1);
    // duplicate header, failing on the last entry itself
    send_fields(SEG_PHDR, 64'd8, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_PHDR, 64'd8, 64'd0, 64'd0, 1'b1);
    // duplicate interpreter, then a load closing the table
    send_fields(SEG_INTERP, 64'd1, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_INTERP, 64'd1, 64'd0, 64'd0, 1'b0);
    send_fields(SEG_LOAD, 64'd3, 64'd1, 64'd2, 1'b1);
    // single-entry tables at the field extremes
    send_fields(32'hFFFF_FFFF, 64'h8000_0000_0000_0000, ALL_ONES, 64'd0, 1'b1);
    send_fields(SEG_LOAD, 64'd0, ALL_ONES, 64'd0, 1'b1);
    send_fields(SEG_LOAD, 64'd1, ALL_ONES, ALL_ONES, 1'b1);
    send_fields(SEG_LOAD, ALL_ONES, 64'd0, ALL_ONES, 1'b1);

    // random tables across settings and idling modes
    for (int p = 0; p < PHASES; p++) begin
      configure(phase_c64[p], phase_be[p], phase_shift[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      while (entries_sent < 20 + (p + 1) * (RANDOM_ENTRIES / PHASES)) send_table();
    end

    drain_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: elf_program_header_checker.f
design/phc_pkg.sv
design/phc_front.sv
design/phc_queue.sv
design/phc_back.sv
design/elf_program_header_checker.sv
tb/phc_verdict_monitor.sv
tb/elf_program_header_checker_tb.sv
